FILE: sv/nearest_neighbor_downscaler_top_assert.svh
// assertion macros for the nearest neighbor downscaler
// used by the queue, back end and scale modules; no other dependencies
`ifndef NEAREST_NEIGHBOR_DOWNSCALER_TOP_ASSERT_SVH
`define NEAREST_NEIGHBOR_DOWNSCALER_TOP_ASSERT_SVH

// same-cycle implication
`define NND_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nnd assertion failed");

// next-cycle implication
`define NND_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nnd assertion failed");

`endif

FILE: sv/nnd_pkg.sv
// shared types and constants of the nearest neighbor downscaler
// no dependencies
`timescale 1ns / 1ps

package nnd_pkg;

	localparam int CFG_W = 13;
	localparam int PIX_W = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;

	localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 13'd800;
	localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 13'd600;
	localparam logic [CFG_W-1:0] DST_WIDTH_RST  = 13'd450;
	localparam logic [CFG_W-1:0] DST_HEIGHT_RST = 13'd338;

	typedef enum logic [1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_DST_WIDTH  = 2'd2,
		REG_DST_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_START,
		SQ_WAIT
	} seq_state_t;

	typedef enum logic [1:0] {
		OP_COL_SCALE = 2'd0,
		OP_ROW_SCALE = 2'd1,
		OP_COL_REM   = 2'd2,
		OP_ROW_REM   = 2'd3
	} div_op_t;

	typedef struct packed {
		logic col_we;
		logic row_we;
		logic big;
	} rem_load_t;

endpackage

FILE: sv/nnd_front.sv
// front end: tracks the source raster position of each accepted word
// uses nnd_pkg
`timescale 1ns / 1ps

module nnd_front #(
	parameter int CW = 13
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [CW-1:0]                sw,
	input  logic [CW-1:0]                sh,
	input  logic                         hold,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [nnd_pkg::PIX_W-1:0]    in_pixel,
	input  logic                         in_frame_start,
	output logic                         push,
	output logic [nnd_pkg::PIX_W-1:0]    push_pixel,
	output logic [CW-1:0]                push_col,
	output logic [CW-1:0]                push_row
);

	logic [CW-1:0] in_col_q, in_row_q;
	logic [CW-1:0] c0, r0, c1, r1, c2, r2, cn, rn, rw;

	always_comb begin
		c0 = in_frame_start ? '0 : in_col_q;
		r0 = in_frame_start ? '0 : in_row_q;
		c1 = c0;
		r1 = r0;
		if (c0 >= sw) begin
			c1 = '0;
			r1 = r0 + CW'(1);
		end
		c2 = c1;
		r2 = r1;
		if (r1 >= sh) begin
			c2 = '0;
			r2 = '0;
		end
		cn = c2 + CW'(1);
		rn = r2;
		rw = r2 + CW'(1);
		if (cn >= sw) begin
			cn = '0;
			rn = (rw >= sh) ? '0 : rw;
		end
	end

	assign in_ready   = !hold;
	assign push       = in_valid && !hold;
	assign push_pixel = in_pixel;
	assign push_col   = c2;
	assign push_row   = r2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
		end else if (push) begin
			in_col_q <= cn;
			in_row_q <= rn;
		end
	end

endmodule

FILE: sv/nnd_queue.sv
// short queue between the front and back ends
// uses nnd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "nearest_neighbor_downscaler_top_assert.svh"

module nnd_queue #(
	parameter int W = 34
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         pop_valid,
	output logic [W-1:0] pop_data
);

	localparam int DEPTH = nnd_pkg::QUEUE_DEPTH;

	logic [W-1:0] mem [DEPTH];
	logic [nnd_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [nnd_pkg::QPTR_W:0] count_q;

	assign full      = count_q == (nnd_pkg::QPTR_W+1)'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`NND_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !full)
	`NND_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, pop_valid)
	`NND_ASSERT_NXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule

FILE: sv/nnd_scale.sv
// scale factor unit: shared bit-serial divider and its sequencer
// recomputes src/dst quotients and remainders after reset and config writes
// uses nnd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "nearest_neighbor_downscaler_top_assert.svh"

module nnd_scale #(
	parameter int CW = 13
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               kick,
	input  logic [CW-1:0]      sw,
	input  logic [CW-1:0]      sh,
	input  logic [CW-1:0]      dw,
	input  logic [CW-1:0]      dh,
	input  logic [CW-1:0]      col_rem,
	input  logic [CW-1:0]      row_rem,
	output logic               busy,
	output logic [CW-1:0]      qw,
	output logic [CW-1:0]      mw,
	output logic [CW-1:0]      qh,
	output logic [CW-1:0]      mh,
	output nnd_pkg::rem_load_t rem_ld,
	output logic [CW-1:0]      rem_val
);

	localparam int CNT_W = $clog2(CW + 1);

	nnd_pkg::seq_state_t state_q, state_d;
	nnd_pkg::div_op_t    op_q, op_d;

	logic [CW-1:0]    div_d_q, div_rem_q, div_quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CW-1:0]    qw_q, mw_q, qh_q, mh_q;

	logic [CW-1:0] dividend, divisor;
	logic          div_start, div_done;
	logic [CW:0]   partial, diff;
	logic          ge;

	always_comb begin
		case (op_q)
			nnd_pkg::OP_COL_SCALE: begin
				dividend = sw;
				divisor  = dw;
			end
			nnd_pkg::OP_ROW_SCALE: begin
				dividend = sh;
				divisor  = dh;
			end
			nnd_pkg::OP_COL_REM: begin
				dividend = col_rem;
				divisor  = dw;
			end
			nnd_pkg::OP_ROW_REM: begin
				dividend = row_rem;
				divisor  = dh;
			end
			default: begin
				dividend = sw;
				divisor  = dw;
			end
		endcase
	end

	assign div_done = (state_q == nnd_pkg::SQ_WAIT) && (cnt_q == '0);

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		div_start = 1'b0;
		case (state_q)
			nnd_pkg::SQ_IDLE: begin
				state_d = nnd_pkg::SQ_IDLE;
			end
			nnd_pkg::SQ_START: begin
				div_start = 1'b1;
				state_d   = nnd_pkg::SQ_WAIT;
			end
			nnd_pkg::SQ_WAIT: begin
				if (cnt_q == '0) begin
					case (op_q)
						nnd_pkg::OP_COL_SCALE: begin
							op_d    = nnd_pkg::OP_ROW_SCALE;
							state_d = nnd_pkg::SQ_START;
						end
						nnd_pkg::OP_ROW_SCALE: begin
							op_d    = nnd_pkg::OP_COL_REM;
							state_d = nnd_pkg::SQ_START;
						end
						nnd_pkg::OP_COL_REM: begin
							op_d    = nnd_pkg::OP_ROW_REM;
							state_d = nnd_pkg::SQ_START;
						end
						default: begin
							state_d = nnd_pkg::SQ_IDLE;
						end
					endcase
				end
			end
			default: begin
				state_d = nnd_pkg::SQ_IDLE;
			end
		endcase
		if (kick) begin
			state_d = nnd_pkg::SQ_START;
			op_d    = nnd_pkg::OP_COL_SCALE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nnd_pkg::SQ_START;
			op_q    <= nnd_pkg::OP_COL_SCALE;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	// restoring divider, one quotient bit a cycle
	assign partial = {div_rem_q, div_quo_q[CW-1]};
	assign diff    = partial - {1'b0, div_d_q};
	assign ge      = partial >= {1'b0, div_d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (div_start) begin
			cnt_q <= CNT_W'(CW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			div_d_q   <= divisor;
			div_rem_q <= '0;
			div_quo_q <= dividend;
		end else if (cnt_q != '0) begin
			div_rem_q <= ge ? diff[CW-1:0] : partial[CW-1:0];
			div_quo_q <= {div_quo_q[CW-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			case (op_q)
				nnd_pkg::OP_COL_SCALE: begin
					qw_q <= div_quo_q;
					mw_q <= div_rem_q;
				end
				nnd_pkg::OP_ROW_SCALE: begin
					qh_q <= div_quo_q;
					mh_q <= div_rem_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign busy          = state_q != nnd_pkg::SQ_IDLE;
	assign qw            = qw_q;
	assign mw            = mw_q;
	assign qh            = qh_q;
	assign mh            = mh_q;
	assign rem_ld.col_we = div_done && (op_q == nnd_pkg::OP_COL_REM);
	assign rem_ld.row_we = div_done && (op_q == nnd_pkg::OP_ROW_REM);
	assign rem_ld.big    = div_quo_q != '0;
	assign rem_val       = div_rem_q;

	`NND_ASSERT_NXT(a_div_load, clk, arst_n, state_q == nnd_pkg::SQ_START, cnt_q == CNT_W'(CW))

endmodule

FILE: sv/nnd_back.sv
// back end: matches source positions against wanted positions, output register
// uses nnd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "nearest_neighbor_downscaler_top_assert.svh"

module nnd_back #(
	parameter int CW = 13
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [CW-1:0]             dw,
	input  logic [CW-1:0]             dh,
	input  logic [CW-1:0]             qw,
	input  logic [CW-1:0]             mw,
	input  logic [CW-1:0]             qh,
	input  logic [CW-1:0]             mh,
	input  nnd_pkg::rem_load_t        rem_ld,
	input  logic [CW-1:0]             rem_val,
	output logic [CW-1:0]             col_rem,
	output logic [CW-1:0]             row_rem,
	input  logic                      item_valid,
	input  logic [nnd_pkg::PIX_W-1:0] item_pixel,
	input  logic [CW-1:0]             item_col,
	input  logic [CW-1:0]             item_row,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [nnd_pkg::PIX_W-1:0] out_pixel,
	output logic                      line_end,
	output logic                      frame_end
);

	localparam int W1 = CW + 1;

	logic [W1-1:0] out_col_q, out_row_q, want_col_q, want_row_q;
	logic [CW-1:0] col_rem_q, row_rem_q;
	logic          col_big_q, row_big_q;

	logic                      ovalid_q;
	logic [nnd_pkg::PIX_W-1:0] opix_q;
	logic                      le_q, fe_q;

	logic          clr, hit, last_col, last_row;
	logic [W1-1:0] oc, orw, wc, wr;
	logic [CW-1:0] cr, rr;
	logic          cb, rb;
	logic [W1-1:0] csum, rsum, cdiff, rdiff;
	logic          cge, rge;
	logic [W1-1:0] wc_adv, wr_adv;
	logic [CW-1:0] cr_adv, rr_adv;
	logic [W1-1:0] oc_n, or_n, wc_n, wr_n;
	logic [CW-1:0] cr_n, rr_n;
	logic          cb_n, rb_n;

	assign pop = item_valid && (!ovalid_q || out_ready);

	always_comb begin
		// a word at the frame origin starts from cleared counters
		clr = (item_col == '0) && (item_row == '0);
		oc  = clr ? '0 : out_col_q;
		orw = clr ? '0 : out_row_q;
		wc  = clr ? '0 : want_col_q;
		wr  = clr ? '0 : want_row_q;
		cr  = clr ? '0 : col_rem_q;
		rr  = clr ? '0 : row_rem_q;
		cb  = clr ? 1'b0 : col_big_q;
		rb  = clr ? 1'b0 : row_big_q;

		hit = (orw < {1'b0, dh}) && ({1'b0, item_row} == wr) && ({1'b0, item_col} == wc);
		last_col = oc == {1'b0, dw - CW'(1)};
		last_row = orw == {1'b0, dh - CW'(1)};

		csum   = {1'b0, cr} + {1'b0, mw};
		cdiff  = csum - {1'b0, dw};
		cge    = csum >= {1'b0, dw};
		cr_adv = cge ? cdiff[CW-1:0] : csum[CW-1:0];
		wc_adv = wc + {1'b0, qw} + W1'(cb | cge);

		rsum   = {1'b0, rr} + {1'b0, mh};
		rdiff  = rsum - {1'b0, dh};
		rge    = rsum >= {1'b0, dh};
		rr_adv = rge ? rdiff[CW-1:0] : rsum[CW-1:0];
		wr_adv = wr + {1'b0, qh} + W1'(rb | rge);

		oc_n = oc;
		or_n = orw;
		wc_n = wc;
		wr_n = wr;
		cr_n = cr;
		rr_n = rr;
		cb_n = cb;
		rb_n = rb;
		if (hit) begin
			if (last_col) begin
				oc_n = '0;
				wc_n = '0;
				cr_n = '0;
				cb_n = 1'b0;
				if (last_row) begin
					or_n = {1'b0, dh};
				end else begin
					or_n = orw + W1'(1);
					wr_n = wr_adv;
					rr_n = rr_adv;
					rb_n = 1'b0;
				end
			end else begin
				oc_n = oc + W1'(1);
				wc_n = wc_adv;
				cr_n = cr_adv;
				cb_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_col_q  <= '0;
			out_row_q  <= '0;
			want_col_q <= '0;
			want_row_q <= '0;
			col_rem_q  <= '0;
			row_rem_q  <= '0;
			col_big_q  <= 1'b0;
			row_big_q  <= 1'b0;
		end else if (pop) begin
			out_col_q  <= oc_n;
			out_row_q  <= or_n;
			want_col_q <= wc_n;
			want_row_q <= wr_n;
			col_rem_q  <= cr_n;
			row_rem_q  <= rr_n;
			col_big_q  <= cb_n;
			row_big_q  <= rb_n;
		end else begin
			if (rem_ld.col_we) begin
				col_rem_q <= rem_val;
				col_big_q <= rem_ld.big;
			end
			if (rem_ld.row_we) begin
				row_rem_q <= rem_val;
				row_big_q <= rem_ld.big;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (pop && hit) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && hit) begin
			opix_q <= item_pixel;
			le_q   <= last_col;
			fe_q   <= last_col && last_row;
		end
	end

	assign col_rem   = col_rem_q;
	assign row_rem   = row_rem_q;
	assign out_valid = ovalid_q;
	assign out_pixel = opix_q;
	assign line_end  = le_q;
	assign frame_end = fe_q;

	`NND_ASSERT_NXT(a_result_loaded, clk, arst_n, pop && hit, ovalid_q)
	`NND_ASSERT_NXT(a_line_restart, clk, arst_n, pop && hit && last_col, out_col_q == '0 && want_col_q == '0)

endmodule

FILE: sv/nearest_neighbor_downscaler_top.sv
// top level of the nearest neighbor downscaler: config registers and wiring
// depends on nnd_pkg, nnd_front, nnd_queue, nnd_scale, nnd_back
//
// channel   dir  signals                       payload
// cfg       in   cfg_we, cfg_index, cfg_data   register write, no read-back
// s_axis    in   tvalid, tready, tdata, tuser  source pixel, frame start
// m_axis    out  tvalid, tready, tdata, tlast, tuser  output pixel, line end, frame end
//
// one source word per cycle unless the divider is busy or the queue is full; a kept word
// reaches m_axis via a queue entry and the output register; sizes go through a shared
// bit-serial divider: after reset and any config write, s_axis_tready stays low until
// it is done; output register decouples m_axis stalls; a four-entry queue sits between
// the position tracker and the matcher, so each side stalls on its own
`timescale 1ns / 1ps

module nearest_neighbor_downscaler_top #(
	parameter int MAX_DIM = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [nnd_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,  // pixel
	input  logic                        s_axis_tuser,  // frame_start
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [7:0]                  m_axis_tdata,  // out_pixel
	output logic                        m_axis_tlast,  // line_end
	output logic                        m_axis_tuser   // frame_end
);

	localparam int CW = $clog2(MAX_DIM + 1);
	localparam int QW = nnd_pkg::PIX_W + 2 * CW;

	logic [nnd_pkg::CFG_W-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
	logic [CW-1:0] sw, sh, dw_c, dh_c, dw, dh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= nnd_pkg::SRC_WIDTH_RST;
			src_height_q <= nnd_pkg::SRC_HEIGHT_RST;
			dst_width_q  <= nnd_pkg::DST_WIDTH_RST;
			dst_height_q <= nnd_pkg::DST_HEIGHT_RST;
		end else if (cfg_we) begin
			case (nnd_pkg::cfg_reg_t'(cfg_index))
				nnd_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				nnd_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_data;
				nnd_pkg::REG_DST_WIDTH:  dst_width_q  <= cfg_data;
				nnd_pkg::REG_DST_HEIGHT: dst_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sizes limited to 1..MAX_DIM, destination no larger than source
	always_comb begin
		sw = (src_width_q == '0) ? CW'(1) :
			(32'(src_width_q) > MAX_DIM) ? CW'(MAX_DIM) : CW'(src_width_q);
		sh = (src_height_q == '0) ? CW'(1) :
			(32'(src_height_q) > MAX_DIM) ? CW'(MAX_DIM) : CW'(src_height_q);
		dw_c = (dst_width_q == '0) ? CW'(1) :
			(32'(dst_width_q) > MAX_DIM) ? CW'(MAX_DIM) : CW'(dst_width_q);
		dh_c = (dst_height_q == '0) ? CW'(1) :
			(32'(dst_height_q) > MAX_DIM) ? CW'(MAX_DIM) : CW'(dst_height_q);
		dw = (dw_c > sw) ? sw : dw_c;
		dh = (dh_c > sh) ? sh : dh_c;
	end

	logic                      busy, full;
	logic                      push, pop, pop_valid;
	logic [nnd_pkg::PIX_W-1:0] push_pixel;
	logic [CW-1:0]             push_col, push_row;
	logic [QW-1:0]             pop_data;
	logic [CW-1:0]             qw, mw, qh, mh, col_rem, row_rem, rem_val;
	nnd_pkg::rem_load_t        rem_ld;

	nnd_front #(.CW(CW)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.sw             (sw),
		.sh             (sh),
		.hold           (busy || full),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.in_pixel       (s_axis_tdata),
		.in_frame_start (s_axis_tuser),
		.push           (push),
		.push_pixel     (push_pixel),
		.push_col       (push_col),
		.push_row       (push_row)
	);

	nnd_queue #(.W(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_row, push_col, push_pixel}),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	nnd_scale #(.CW(CW)) u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.kick    (cfg_we),
		.sw      (sw),
		.sh      (sh),
		.dw      (dw),
		.dh      (dh),
		.col_rem (col_rem),
		.row_rem (row_rem),
		.busy    (busy),
		.qw      (qw),
		.mw      (mw),
		.qh      (qh),
		.mh      (mh),
		.rem_ld  (rem_ld),
		.rem_val (rem_val)
	);

	nnd_back #(.CW(CW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.dw         (dw),
		.dh         (dh),
		.qw         (qw),
		.mw         (mw),
		.qh         (qh),
		.mh         (mh),
		.rem_ld     (rem_ld),
		.rem_val    (rem_val),
		.col_rem    (col_rem),
		.row_rem    (row_rem),
		.item_valid (pop_valid),
		.item_pixel (pop_data[nnd_pkg::PIX_W-1:0]),
		.item_col   (pop_data[nnd_pkg::PIX_W +: CW]),
		.item_row   (pop_data[nnd_pkg::PIX_W + CW +: CW]),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_pixel  (m_axis_tdata),
		.line_end   (m_axis_tlast),
		.frame_end  (m_axis_tuser)
	);

endmodule
